### rtl/acfp_pkg.sv
// Shared constants and character helpers for the ASCII coordinate frame parser.
// No dependencies.
package acfp_pkg;

  localparam int FIELD_COUNT = 16;
  localparam int FIELD_W     = $clog2(FIELD_COUNT + 1);

  localparam int IDX_W   = 4;
  localparam int VALUE_W = 16;

  localparam logic [7:0] CHAR_OPEN  = 8'h40;  // '@'
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam logic signed [20:0] SAT_MAX = 21'sd32767;
  localparam logic signed [20:0] SAT_MIN = -21'sd32768;

  // result payload: index in the low bits, then the value, padded to bytes
  localparam int OUT_DATA_W = ((IDX_W + VALUE_W + 7) / 8) * 8;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

endpackage

### rtl/ascii_coordinate_frame_parser.sv
// ASCII coordinate frame parser: top level with field state and result register.
// Depends on acfp_pkg.
//
// Takes one received UART byte per transfer and returns a parsed coordinate
// whenever a field closes. A burst (in_tuser marks its first byte, in_tlast
// its last) that opens with '@' starts a frame of up to FIELD_COUNT signed
// decimal fields, given out as x1,y1..x8,y8 with values saturated to 16 bits.
// Each byte is handled as it is accepted: the field state updates at the transfer
// and any result lands in a single output register, so a byte is accepted
// every cycle as long as the result side keeps taking results. A result
// waiting in the output register stalls the input only when out_tready is low.
module ascii_coordinate_frame_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] rx_byte
  input  logic                             in_tuser,   // [0] burst_first
  input  logic                             in_tlast,   // burst_last
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [acfp_pkg::OUT_DATA_W-1:0]  out_tdata,  // [3:0] field_index, [19:4] coord_value
  output logic                             out_tlast   // frame_last
);
  import acfp_pkg::*;

  logic                      in_frame_r, in_frame_nxt;
  logic [FIELD_W-1:0]        field_r, field_nxt;
  logic signed [VALUE_W-1:0] acc_r, acc_nxt;
  logic                      neg_r, neg_nxt;
  logic                      started_r, started_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]          out_idx_r, out_idx_nxt;
  logic signed [VALUE_W-1:0] out_val_r, out_val_nxt;
  logic                      out_last_r, out_last_nxt;

  logic                      accept;
  logic [7:0]                c;
  logic                      c_digit, c_blank, c_sign, taken, emit;
  logic signed [20:0]        prod, sum;
  logic signed [VALUE_W-1:0] acc_digit;
  logic [FIELD_W+IDX_W-1:0]  field_ext;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign c         = in_tdata;

  assign c_digit = is_digit(c);
  assign c_blank = !started_r && is_blank(c);
  assign c_sign  = !started_r && ((c == CHAR_PLUS) || (c == CHAR_MINUS));
  assign taken   = c_digit || c_blank || c_sign;

  // acc * 10 = acc * 8 + acc * 2, then add or subtract the digit and saturate
  assign prod = (21'(acc_r) <<< 3) + (21'(acc_r) <<< 1);
  assign sum  = neg_r ? (prod - 21'(c - CHAR_ZERO)) : (prod + 21'(c - CHAR_ZERO));
  always_comb begin
    if (sum > SAT_MAX) begin
      acc_digit = VALUE_W'(SAT_MAX);
    end else if (sum < SAT_MIN) begin
      acc_digit = VALUE_W'(SAT_MIN);
    end else begin
      acc_digit = sum[VALUE_W-1:0];
    end
  end

  assign field_ext = {{IDX_W{1'b0}}, field_r};

  always_comb begin
    in_frame_nxt  = in_frame_r;
    field_nxt     = field_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_idx_nxt   = out_idx_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    emit          = 1'b0;

    if (accept) begin
      if (in_tuser) begin
        // new burst: restart, '@' opens a frame unless the burst ends here
        in_frame_nxt = (c == CHAR_OPEN) && !in_tlast;
        field_nxt    = '0;
        acc_nxt      = '0;
        neg_nxt      = 1'b0;
        started_nxt  = 1'b0;
      end else if (in_frame_r) begin
        if (field_r < FIELD_W'(FIELD_COUNT)) begin
          if (c_digit) begin
            acc_nxt     = acc_digit;
            started_nxt = 1'b1;
          end else if (c_sign) begin
            neg_nxt     = (c == CHAR_MINUS);
            started_nxt = 1'b1;
          end
          emit = !taken || in_tlast;
          if (emit) begin
            out_valid_nxt = 1'b1;
            out_idx_nxt   = field_ext[IDX_W-1:0];
            out_val_nxt   = c_digit ? acc_digit : acc_r;
            out_last_nxt  = (field_r == FIELD_W'(FIELD_COUNT - 1));
            field_nxt     = field_r + 1'b1;
            acc_nxt       = '0;
            neg_nxt       = 1'b0;
            started_nxt   = 1'b0;
          end
        end
        if (in_tlast) begin
          // burst end closes the frame
          in_frame_nxt = 1'b0;
          field_nxt    = '0;
          acc_nxt      = '0;
          neg_nxt      = 1'b0;
          started_nxt  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      field_r     <= '0;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_frame_r  <= in_frame_nxt;
      field_r     <= field_nxt;
      acc_r       <= acc_nxt;
      neg_r       <= neg_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_idx_r  <= out_idx_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - IDX_W - VALUE_W){1'b0}}, out_val_r, out_idx_r};
  assign out_tlast  = out_last_r;

endmodule
